/* sv/escf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escf_pkg: shared types and constants of the escaped crc32 packet framer
// Payload structs of both channels, the job word that runs from front to
// back, the back sequencer phases and the crc32 byte step.
// ----------------------------------------------------------------------------
package escf_pkg;

   // line codes
   localparam logic [7:0] START_BYTE = 8'hFF;
   localparam logic [7:0] ESC_BYTE   = 8'hFE;

   // reflected crc32
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // last index of the header bytes and of the crc bytes
   localparam logic [2:0] HDR_LAST = 3'd4;
   localparam logic [2:0] CRC_LAST = 3'd3;

   typedef struct packed {
      logic [15:0] packet_address;
      logic [7:0]  packet_flags;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_last;
      logic       packet_end;
   } rsp_payload_type;

   // one classified input beat, queued between front and back
   typedef struct packed {
      logic            first;
      logic            last;
      req_payload_type beat;
   } job_type;

   typedef enum logic [1:0] {
      PH_START,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CRC
   } phase_type;

   // one byte through the crc register, lsb first
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // crc register after the start byte
   localparam logic [31:0] CRC_AFTER_START = crc32_byte(CRC_INIT, START_BYTE);

endpackage
`default_nettype wire

/* sv/escf_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escf_front: input side of the framer
// Accepts input beats, tracks the bytes left in the packet and tags each beat
// as first and/or last of its packet before queueing it.
// ----------------------------------------------------------------------------
module escf_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   output logic                     full,
   input  escf_pkg::req_payload_type req_payload,
   input  wire                      queue_full,
   output logic                     queue_push,
   output escf_pkg::job_type        queue_data
);
   import escf_pkg::*;

   logic [15:0] bytes_left_ff, bytes_left_in;
   logic        accept;
   logic        is_start;
   logic        drop;
   logic [15:0] remaining;
   logic [15:0] next_left;

   // classify the beat
   always_comb begin
      accept    = push && !queue_full;
      is_start  = (bytes_left_ff == 16'd0);
      drop      = is_start && (req_payload.payload_length == 16'd0);
      remaining = is_start ? req_payload.payload_length : bytes_left_ff;
      next_left = remaining - 16'd1;
      queue_push = accept && !drop;
      queue_data.first = is_start;
      queue_data.last  = (next_left == 16'd0);
      queue_data.beat  = req_payload;
      bytes_left_in = (accept && !drop) ? next_left : bytes_left_ff;
   end

   assign full = queue_full;

   // packet byte counter
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 16'd0;
      end else begin
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule
`default_nettype wire

/* sv/escf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escf_queue: job queue between front and back
// Small circular buffer of classified beats; head is shown while not empty.
// ----------------------------------------------------------------------------
module escf_queue #(
   parameter int DEPTH = 4
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                wr_en,
   input  escf_pkg::job_type  wr_data,
   output logic               is_full,
   input  wire                rd_en,
   output logic               is_empty,
   output escf_pkg::job_type  rd_data
);
   import escf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   // pointer and fill update
   always_comb begin
      is_full  = (count_ff == CNT_FULL);
      is_empty = (count_ff == '0);
      do_wr    = wr_en && !is_full;
      do_rd    = rd_en && !is_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
      rd_data = mem_ff[rd_ptr_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

/* sv/escf_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escf_back: line side of the framer
// Walks each queued job through start, header, payload and crc bytes, adds
// escape bytes, keeps the running crc and drives the output register.
// ----------------------------------------------------------------------------
module escf_back (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       job_empty,
   input  escf_pkg::job_type         job,
   output logic                      job_pop,
   output logic                      empty,
   input  wire                       pop,
   output escf_pkg::rsp_payload_type rsp_payload
);
   import escf_pkg::*;

   phase_type       phase_ff, phase_in;
   logic [2:0]      idx_ff, idx_in;
   logic            esc_done_ff, esc_done_in;
   logic            started_ff, started_in;
   logic [31:0]     crc_ff, crc_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   phase_type       cur_phase;
   logic [2:0]      cur_idx;
   logic [7:0]      byte_val;
   logic [31:0]     crc_fin;
   logic [31:0]     crc_step;
   logic            need_esc;
   logic            emit_esc;
   logic            advance;
   logic            job_done;

   // current byte of the head job
   always_comb begin
      cur_phase = started_ff ? phase_ff : (job.first ? PH_START : PH_PAYLOAD);
      cur_idx   = started_ff ? idx_ff : 3'd0;
      crc_fin   = ~crc_ff;
      byte_val  = START_BYTE;
      unique case (cur_phase)
         PH_START: begin
            byte_val = START_BYTE;
         end
         PH_HEADER: begin
            unique case (cur_idx)
               3'd0:    byte_val = job.beat.packet_address[7:0];
               3'd1:    byte_val = job.beat.packet_address[15:8];
               3'd2:    byte_val = job.beat.packet_flags;
               3'd3:    byte_val = job.beat.payload_length[7:0];
               default: byte_val = job.beat.payload_length[15:8];
            endcase
         end
         PH_PAYLOAD: begin
            byte_val = job.beat.data_byte;
         end
         default: begin
            unique case (cur_idx[1:0])
               2'd0:    byte_val = crc_fin[7:0];
               2'd1:    byte_val = crc_fin[15:8];
               2'd2:    byte_val = crc_fin[23:16];
               default: byte_val = crc_fin[31:24];
            endcase
         end
      endcase
      need_esc = (cur_phase != PH_START)
                 && ((byte_val == ESC_BYTE) || (byte_val == START_BYTE));
      emit_esc = need_esc && !esc_done_ff;
      crc_step = crc32_byte(crc_ff, byte_val);
   end

   // sequencer next state and output beat
   always_comb begin
      advance     = !job_empty && (!out_valid_ff || pop);
      job_done    = 1'b0;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      esc_done_in = esc_done_ff;
      started_in  = started_ff;
      crc_in      = crc_ff;
      out_in.line_byte  = emit_esc ? ESC_BYTE : byte_val;
      out_in.run_last   = 1'b0;
      out_in.packet_end = 1'b0;
      if (emit_esc) begin
         esc_done_in = 1'b1;
         started_in  = 1'b1;
         phase_in    = cur_phase;
         idx_in      = cur_idx;
      end else begin
         esc_done_in = 1'b0;
         started_in  = 1'b1;
         unique case (cur_phase)
            PH_START: begin
               crc_in   = CRC_AFTER_START;
               phase_in = PH_HEADER;
               idx_in   = 3'd0;
            end
            PH_HEADER: begin
               crc_in = crc_step;
               if (cur_idx == HDR_LAST) begin
                  phase_in = PH_PAYLOAD;
                  idx_in   = 3'd0;
               end else begin
                  phase_in = PH_HEADER;
                  idx_in   = cur_idx + 3'd1;
               end
            end
            PH_PAYLOAD: begin
               crc_in = crc_step;
               if (job.last) begin
                  phase_in = PH_CRC;
                  idx_in   = 3'd0;
               end else begin
                  job_done        = 1'b1;
                  out_in.run_last = 1'b1;
               end
            end
            default: begin
               if (cur_idx == CRC_LAST) begin
                  crc_in            = CRC_INIT;
                  job_done          = 1'b1;
                  out_in.run_last   = 1'b1;
                  out_in.packet_end = 1'b1;
               end else begin
                  phase_in = PH_CRC;
                  idx_in   = cur_idx + 3'd1;
               end
            end
         endcase
         if (job_done) begin
            started_in = 1'b0;
         end
      end
      job_pop = advance && job_done;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // sequencer control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         idx_ff       <= 3'd0;
         esc_done_ff  <= 1'b0;
         started_ff   <= 1'b0;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff    <= phase_in;
            idx_ff      <= idx_in;
            esc_done_ff <= esc_done_in;
            started_ff  <= started_in;
            crc_ff      <= crc_in;
         end
      end
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign empty       = !out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
`default_nettype wire

/* sv/escaped_crc32_packet_framer_unit.sv */
// Escaped crc32 packet framer.
// Input channel: push / full with req_payload (address, flags, length, data
// byte). A beat is taken when push is high and full is low. The first beat of
// a packet supplies address, flags and length; a first beat with length zero
// is dropped and produces nothing.
// Result channel: empty / pop with rsp_payload, one line byte per beat.
// run_last marks the last line byte caused by an input beat, packet_end the
// final crc byte of a frame.
// Throughput: one line byte per cycle while jobs wait and the receiver pops. A
// payload beat gives one line byte, two with an escape; the first beat adds 6 to
// 11 bytes of start and header, the last beat 4 to 8 crc bytes, up to 21 bytes for one beat.
// The rate is set by the single-byte back sequencer.
// With the line side idle, a taken beat is first written into the queue, then
// its first line byte is loaded into the output register, where it can be popped.
// A queue of QUEUE_DEPTH beats sits between front and back; full rises when
// it fills, so input keeps flowing while the receiver stalls briefly.
// Reset (synchronous) empties the queue and the output register, clears the
// packet byte counter and sets the crc register to all ones.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_crc32_packet_framer_unit: top level of the framer
// Front classifies input beats, queue decouples, back emits escaped line
// bytes with header and crc32.
// ----------------------------------------------------------------------------
module escaped_crc32_packet_framer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   output logic                      full,
   input  escf_pkg::req_payload_type req_payload,
   output logic                      empty,
   input  wire                       pop,
   output escf_pkg::rsp_payload_type rsp_payload
);
   import escf_pkg::*;

   logic    queue_full;
   logic    queue_push;
   logic    queue_empty;
   logic    queue_pop;
   job_type queue_wr;
   job_type queue_head;

   // input side
   escf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_data  (queue_wr)
   );

   // job queue
   escf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (queue_push),
      .wr_data  (queue_wr),
      .is_full  (queue_full),
      .rd_en    (queue_pop),
      .is_empty (queue_empty),
      .rd_data  (queue_head)
   );

   // line side
   escf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_empty   (queue_empty),
      .job         (queue_head),
      .job_pop     (queue_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

/* sv/escf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escf_checker: port checks of the framer
// Watches the top level ports for reset behavior, beat stability and the
// marking of frame ends.
// ----------------------------------------------------------------------------
module escf_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       full,
   input wire                       empty,
   input wire                       pop,
   input escf_pkg::rsp_payload_type rsp_payload
);
   import escf_pkg::*;

   // a waiting beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_payload)))
      else $error("result beat changed while stalled");

   // reset leaves no result waiting
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result shown right after reset");

   // reset leaves room for input
   a_reset_room: assert property (@(posedge clock)
      reset |=> !full)
      else $error("input blocked right after reset");

   // a frame end also ends the beat's run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_payload.packet_end) |-> rsp_payload.run_last)
      else $error("frame end without run end");

endmodule

bind escaped_crc32_packet_framer_unit escf_checker u_escf_checker (
   .clock       (clock),
   .reset       (reset),
   .full        (full),
   .empty       (empty),
   .pop         (pop),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

/* bench/escaped_crc32_packet_framer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_crc32_packet_framer_unit_tb: regression bench of the frame builder
// Drives payload beats with random gaps, keeps a bit-true model of start,
// header, escaping and crc32, and checks every line byte in order.
// ----------------------------------------------------------------------------
module escaped_crc32_packet_framer_unit_tb;
   import escf_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   // line byte model and in-order checker
   class frame_scoreboard;
      rsp_payload_type line_bytes_due[$];
      rsp_payload_type burst[$];
      logic [31:0]     crc_reg;
      logic [15:0]     payload_left;
      int              errors;

      function new();
         crc_reg      = CRC_INIT;
         payload_left = '0;
         errors       = 0;
      endfunction

      // reflected crc32, one byte lsb first
      function logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b);
         logic [31:0] c;
         c = crc ^ {24'd0, b};
         for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         return c;
      endfunction

      function void add_raw(logic [7:0] b);
         rsp_payload_type r;
         r.line_byte  = b;
         r.run_last   = 1'b0;
         r.packet_end = 1'b0;
         burst.push_back(r);
      endfunction

      function void add_escaped(logic [7:0] b);
         if (b == ESC_BYTE || b == START_BYTE) begin
            add_raw(ESC_BYTE);
         end
         add_raw(b);
      endfunction

      // byte goes into the crc and onto the line
      function void add_data(logic [7:0] b);
         crc_reg = crc_update(crc_reg, b);
         add_escaped(b);
      endfunction

      // expected line bytes of one accepted input beat
      function void note_beat(req_payload_type beat);
         logic [31:0] crc_final;
         burst.delete();
         if (payload_left == 16'd0) begin
            // zero length at packet start is dropped
            if (beat.payload_length == 16'd0) begin
               return;
            end
            payload_left = beat.payload_length;
            crc_reg      = crc_update(CRC_INIT, START_BYTE);
            add_raw(START_BYTE);
            add_data(beat.packet_address[7:0]);
            add_data(beat.packet_address[15:8]);
            add_data(beat.packet_flags);
            add_data(beat.payload_length[7:0]);
            add_data(beat.payload_length[15:8]);
         end
         add_data(beat.data_byte);
         payload_left = payload_left - 16'd1;
         // frame trailer, low byte first
         if (payload_left == 16'd0) begin
            crc_final = ~crc_reg;
            add_escaped(crc_final[7:0]);
            add_escaped(crc_final[15:8]);
            add_escaped(crc_final[23:16]);
            add_escaped(crc_final[31:24]);
            burst[burst.size() - 1].packet_end = 1'b1;
            crc_reg = CRC_INIT;
         end
         burst[burst.size() - 1].run_last = 1'b1;
         foreach (burst[i]) begin
            line_bytes_due.push_back(burst[i]);
         end
      endfunction

      // compare one popped line byte with the oldest expected one
      function void check_beat(rsp_payload_type got);
         rsp_payload_type want;
         if (line_bytes_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("unexpected line byte %02h last %b end %b",
                        got.line_byte, got.run_last, got.packet_end);
            end
            return;
         end
         want = line_bytes_due.pop_front();
         if (got.line_byte !== want.line_byte || got.run_last !== want.run_last ||
             got.packet_end !== want.packet_end) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display({"mismatch: expected byte %02h last %b end %b,",
                         " got byte %02h last %b end %b"},
                        want.line_byte, want.run_last, want.packet_end,
                        got.line_byte, got.run_last, got.packet_end);
            end
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            push  = 1'b0;
   logic            pop   = 1'b0;
   req_payload_type req_payload = '0;
   logic            full;
   logic            empty;
   rsp_payload_type rsp_payload;

   int              tx_idle_pct = 0;
   int              rx_idle_pct = 0;
   int              cycle_count = 0;
   frame_scoreboard frames;

   escaped_crc32_packet_framer_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("escaped_crc32_packet_framer_unit regression: fail");
         $finish;
      end
   end

   // receiver: random stalls, check each popped beat
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         frames.check_beat(rsp_payload);
      end
   end

   // payload byte, often an escape candidate
   function automatic logic [7:0] pick_data();
      if ($urandom_range(4) == 0) begin
         return ($urandom_range(1) == 0) ? ESC_BYTE : START_BYTE;
      end
      return 8'($urandom_range(255));
   endfunction

   // one input beat with random gaps before it
   task automatic send_beat(input req_payload_type beat);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (full) @(posedge clock);
      frames.note_beat(beat);
   endtask

   // whole packet; header fields after the first beat are junk
   task automatic send_packet(input logic [15:0] addr, input logic [7:0] flags,
                              input logic [15:0] len);
      req_payload_type beat;
      beat.packet_address = addr;
      beat.packet_flags   = flags;
      beat.payload_length = len;
      beat.data_byte      = pick_data();
      send_beat(beat);
      for (int i = 1; i < int'(len); i++) begin
         beat.packet_address = 16'($urandom);
         beat.packet_flags   = 8'($urandom);
         beat.payload_length = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
         beat.data_byte      = pick_data();
         send_beat(beat);
      end
   endtask

   // mostly short packets, some longer, dropped zero-length beats between
   task automatic run_random(input int n_items);
      req_payload_type beat;
      int              sent;
      int              len;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            beat.packet_address = 16'($urandom);
            beat.packet_flags   = 8'($urandom);
            beat.payload_length = 16'd0;
            beat.data_byte      = pick_data();
            send_beat(beat);
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
            send_packet(16'($urandom), 8'($urandom), 16'(len));
            sent += len;
         end
      end
   endtask

   // address whose one-byte frame ends in a crc byte that needs an escape
   function automatic logic [15:0] crc_escape_address();
      logic [31:0] c;
      for (int a = 0; a < 65536; a++) begin
         c = frames.crc_update(CRC_INIT, START_BYTE);
         c = frames.crc_update(c, 8'(a));
         c = frames.crc_update(c, 8'(a >> 8));
         c = frames.crc_update(c, 8'd0);
         c = frames.crc_update(c, 8'd1);
         c = frames.crc_update(c, 8'd0);
         c = frames.crc_update(c, 8'd0);
         c = ~c;
         if (c[31:24] >= ESC_BYTE) begin
            return 16'(a);
         end
      end
      return 16'd0;
   endfunction

   initial begin
      frames      = new();
      tx_idle_pct = 33;
      rx_idle_pct = 47;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: dropped beat, extremes, escapes, junk headers mid-packet
      send_beat(req_payload_type'{16'hFFFF, 8'hFF, 16'd0, 8'hFF});
      send_beat(req_payload_type'{16'h0000, 8'h00, 16'd1, 8'h00});
      send_beat(req_payload_type'{16'hFFFF, 8'hFF, 16'd1, 8'hFF});
      send_beat(req_payload_type'{16'hFEFF, 8'hFE, 16'd3, 8'hFE});
      send_beat(req_payload_type'{16'hFFFF, 8'hFF, 16'd0, 8'h00});
      send_beat(req_payload_type'{16'h0000, 8'h00, 16'hFFFF, 8'hFF});
      send_beat(req_payload_type'{crc_escape_address(), 8'h00, 16'd1, 8'h00});
      send_beat(req_payload_type'{16'h1234, 8'h5A, 16'd0, 8'h77});
      send_beat(req_payload_type'{16'h0001, 8'h80, 16'd2, 8'h7F});
      send_beat(req_payload_type'{16'h0000, 8'h00, 16'd0, 8'h80});

      // random traffic under three idling mixes
      run_random(30);
      tx_idle_pct = 47;
      rx_idle_pct = 33;
      run_random(30);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_random(30);
      @(negedge clock);
      push <= 1'b0;

      // drain and settle
      while (frames.line_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames.errors == 0 && frames.line_bytes_due.size() == 0) begin
         $display("escaped_crc32_packet_framer_unit regression: pass");
      end else begin
         $display("escaped_crc32_packet_framer_unit regression: fail");
      end
      $finish;
   end

endmodule
